@@ hdl/fa_pkg.sv @@
`default_nettype none

package fa_pkg;

    localparam int DIM_BITS   = 11;
    localparam int POS_BITS   = 10;
    localparam int IDX_BITS   = 20;
    localparam int SUM_BITS   = 32;
    localparam int ALPHA_BITS = 17;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_BITS-1:0]   DIM_MIN   = 11'd1;
    localparam logic [DIM_BITS-1:0]   DIM_MAX   = 11'd1024;
    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 17'h10000;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_ENABLE  = 3'd2;
    localparam logic [2:0] REG_LOWPASS = 3'd3;
    localparam logic [2:0] REG_ALPHA   = 3'd4;

    localparam logic [DIM_BITS-1:0]   RESET_WIDTH  = 11'd640;
    localparam logic [DIM_BITS-1:0]   RESET_HEIGHT = 11'd480;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_COPY,
        OP_BLEND,
        OP_AVERAGE
    } fa_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_BLEND,
        ST_DIVIDE,
        ST_FINISH
    } fa_state_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]   frame_width;
        logic [DIM_BITS-1:0]   frame_height;
        logic                  accumulate_enable;
        logic                  lowpass_mode;
        logic [ALPHA_BITS-1:0] blend_alpha;
    } fa_cfg_t;

    typedef struct packed {
        fa_op_t                op;
        logic                  adding;
        logic                  last;
        logic [POS_BITS-1:0]   col;
        logic [POS_BITS-1:0]   row;
        logic [IDX_BITS-1:0]   idx;
    } fa_ctl_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_MIN;
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/fa_divider.sv @@
`default_nettype none

module fa_divider #(
    parameter int DIVIDEND_BITS = 32,
    parameter int DIVISOR_BITS  = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic                          done,
    output logic [DIVIDEND_BITS-1:0]      quotient
);

    localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  div_reg;

    logic [DIVISOR_BITS:0]    rem_shift;
    logic [DIVISOR_BITS:0]    rem_sub;
    logic                     fits;

    // One quotient bit per cycle, restoring
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        fits      = rem_shift >= {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(DIVIDEND_BITS);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= fits ? rem_sub[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule

`default_nettype wire

@@ hdl/fa_queue.sv @@
`default_nettype none

module fa_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = count_reg != CNT_BITS'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("queue overfilled");

endmodule

`default_nettype wire

@@ hdl/fa_front.sv @@
`default_nettype none

module fa_front #(
    parameter int MAX_PIXELS  = 1048576,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fa_pkg::fa_cfg_t               cfg,
    input  wire logic                          restart,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [SAMPLE_BITS-1:0]        s_sample,
    input  wire logic                          q_ready,
    output logic                               q_push,
    output fa_pkg::fa_ctl_t                    q_ctl,
    output logic [SAMPLE_BITS-1:0]             q_sample,
    output logic [COUNT_BITS-1:0]              q_count,
    output logic [fa_pkg::ALPHA_BITS-1:0]      q_alpha
);

    import fa_pkg::*;

    logic [POS_BITS-1:0]   column_count_reg;
    logic [POS_BITS-1:0]   column_count_next;
    logic [POS_BITS-1:0]   row_count_reg;
    logic [POS_BITS-1:0]   row_count_next;
    logic [COUNT_BITS-1:0] frames_seen_reg;
    logic [COUNT_BITS-1:0] frames_seen_next;
    logic                  adding_reg;
    logic                  adding_next;

    logic [DIM_BITS-1:0]   w;
    logic [DIM_BITS-1:0]   h;
    logic [POS_BITS-1:0]   col;
    logic [POS_BITS-1:0]   row;
    logic [DIM_BITS-1:0]   col_inc;
    logic [DIM_BITS-1:0]   row_inc;
    logic [IDX_BITS:0]     idx_full;
    logic                  in_range;
    logic                  frame_start;
    logic                  accept;

    assign s_ready = q_ready;
    assign q_push  = s_valid;
    assign accept  = s_valid && q_ready;

    always_comb begin
        w = clamp_dim(cfg.frame_width);
        h = clamp_dim(cfg.frame_height);

        // Wrap counters left over from a larger geometry
        col = (DIM_BITS'(column_count_reg) >= w) ? '0 : column_count_reg;
        row = (DIM_BITS'(row_count_reg) >= h) ? '0 : row_count_reg;

        idx_full = (IDX_BITS+1)'(row) * (IDX_BITS+1)'(w) + (IDX_BITS+1)'(col);
        in_range = 32'(idx_full) < 32'(MAX_PIXELS);

        frame_start      = cfg.accumulate_enable && (col == '0) && (row == '0);
        frames_seen_next = frames_seen_reg;
        adding_next      = adding_reg;
        if (frame_start) begin
            if (frames_seen_reg == '0) begin
                frames_seen_next = COUNT_BITS'(1);
                adding_next      = 1'b1;
            end else if (frames_seen_reg != '1) begin
                frames_seen_next = frames_seen_reg + 1'b1;
                adding_next      = 1'b1;
            end else begin
                adding_next = 1'b0;
            end
        end

        if (!cfg.accumulate_enable || !in_range || frames_seen_next == '0) begin
            q_ctl.op = OP_PASS;
        end else if (frames_seen_next == COUNT_BITS'(1)) begin
            q_ctl.op = OP_COPY;
        end else if (cfg.lowpass_mode) begin
            q_ctl.op = OP_BLEND;
        end else begin
            q_ctl.op = OP_AVERAGE;
        end
        q_ctl.adding = adding_next;
        q_ctl.last   = (DIM_BITS'(col) == w - 1'b1) && (DIM_BITS'(row) == h - 1'b1);
        q_ctl.col    = col;
        q_ctl.row    = row;
        q_ctl.idx    = idx_full[IDX_BITS-1:0];

        col_inc = DIM_BITS'(col) + 1'b1;
        row_inc = DIM_BITS'(row) + 1'b1;
        if (col_inc >= w) begin
            column_count_next = '0;
            row_count_next    = (row_inc >= h) ? '0 : row_inc[POS_BITS-1:0];
        end else begin
            column_count_next = col_inc[POS_BITS-1:0];
            row_count_next    = row;
        end
    end

    assign q_sample = s_sample;
    assign q_count  = frames_seen_next;
    assign q_alpha  = (cfg.blend_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.blend_alpha;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            frames_seen_reg  <= '0;
            adding_reg       <= 1'b0;
        end else if (accept) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            frames_seen_reg  <= frames_seen_next;
            adding_reg       <= adding_next;
        end
    end

    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && q_ctl.last) |=> (column_count_reg == '0 && row_count_reg == '0))
        else $error("frame end did not wrap position");

endmodule

`default_nettype wire

@@ hdl/fa_back.sv @@
`default_nettype none

module fa_back #(
    parameter int MAX_PIXELS  = 1048576,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire fa_pkg::fa_ctl_t               q_ctl,
    input  wire logic [SAMPLE_BITS-1:0]        q_sample,
    input  wire logic [COUNT_BITS-1:0]         q_count,
    input  wire logic [fa_pkg::ALPHA_BITS-1:0] q_alpha,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [SAMPLE_BITS-1:0]             out_value,
    output logic [fa_pkg::POS_BITS-1:0]        out_col,
    output logic [fa_pkg::POS_BITS-1:0]        out_row,
    output logic                               out_last
);

    import fa_pkg::*;

    localparam int ADDR_BITS = $clog2(MAX_PIXELS);
    localparam int PROD_BITS = ALPHA_BITS + SUM_BITS;
    localparam logic [SUM_BITS-1:0] SAMPLE_MAX = (SUM_BITS'(1) << SAMPLE_BITS) - 1'b1;

    logic [SUM_BITS-1:0] store_mem [MAX_PIXELS];

    fa_state_t             state_reg;
    fa_state_t             state_next;

    fa_ctl_t               ctl_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [ALPHA_BITS-1:0] alpha_reg;
    logic [SUM_BITS-1:0]   rd_data_reg;
    logic [PROD_BITS-1:0]  product_reg;
    logic                  neg_reg;
    logic [SUM_BITS-1:0]   store_reg;
    logic [SUM_BITS-1:0]   result_reg;

    logic                  out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_value_reg;
    logic [POS_BITS-1:0]   out_col_reg;
    logic [POS_BITS-1:0]   out_row_reg;
    logic                  out_last_reg;

    logic                  rd_en;
    logic                  div_start;
    logic                  div_done;
    logic [SUM_BITS-1:0]   div_quotient;
    logic                  out_load;
    logic                  wr_en;

    logic [SUM_BITS-1:0]   x_ext;
    logic [SUM_BITS-1:0]   diff;
    logic [SUM_BITS:0]     sum_full;
    logic [SUM_BITS-1:0]   avg_store;
    logic [SUM_BITS:0]     step;
    logic [SUM_BITS:0]     blend_full;
    logic [SUM_BITS-1:0]   blended;

    always_comb begin
        x_ext      = SUM_BITS'(sample_reg);
        diff       = (x_ext >= rd_data_reg) ? x_ext - rd_data_reg : rd_data_reg - x_ext;
        sum_full   = {1'b0, rd_data_reg} + {1'b0, x_ext};
        // Saturate the running sum at the store width
        avg_store  = ctl_reg.adding ? (sum_full[SUM_BITS] ? '1 : sum_full[SUM_BITS-1:0])
                                    : rd_data_reg;
        step       = product_reg[PROD_BITS-1:16];
        blend_full = neg_reg ? {1'b0, rd_data_reg} - step : {1'b0, rd_data_reg} + step;
        blended    = blend_full[SUM_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_ready    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    state_next = (q_ctl.op == OP_PASS) ? ST_FINISH : ST_CALC;
                end
            end
            ST_CALC: begin
                case (ctl_reg.op)
                    OP_BLEND:   state_next = ST_BLEND;
                    OP_AVERAGE: begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    default:    state_next = ST_FINISH;
                endcase
            end
            ST_BLEND: begin
                state_next = ST_FINISH;
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hand over once the output register is free or draining
                if (!out_valid_reg || out_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign rd_en = q_valid && q_ready;
    assign wr_en = out_load && (ctl_reg.op != OP_PASS);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[ADDR_BITS'(q_ctl.idx)];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[ADDR_BITS'(ctl_reg.idx)] <= store_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            ctl_reg    <= q_ctl;
            sample_reg <= q_sample;
            count_reg  <= q_count;
            alpha_reg  <= q_alpha;
            result_reg <= SUM_BITS'(q_sample);
        end
        if (state_reg == ST_CALC) begin
            case (ctl_reg.op)
                OP_BLEND: begin
                    product_reg <= PROD_BITS'(alpha_reg) * PROD_BITS'(diff);
                    neg_reg     <= x_ext < rd_data_reg;
                end
                OP_AVERAGE: begin
                    store_reg <= avg_store;
                end
                default: begin
                    store_reg  <= x_ext;
                    result_reg <= x_ext;
                end
            endcase
        end
        if (state_reg == ST_BLEND) begin
            store_reg  <= blended;
            result_reg <= blended;
        end
        if (state_reg == ST_DIVIDE && div_done) begin
            result_reg <= div_quotient;
        end
    end

    fa_divider #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (avg_store),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value_reg <= (result_reg > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_BITS-1:0]
                                                       : result_reg[SAMPLE_BITS-1:0];
            out_col_reg   <= ctl_reg.col;
            out_row_reg   <= ctl_reg.row;
            out_last_reg  <= ctl_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_last  = out_last_reg;

    a_pop_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && q_ctl.op != OP_PASS) |=> state_reg == ST_CALC)
        else $error("store read not followed by calc");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented");

endmodule

`default_nettype wire

@@ hdl/frame_accumulator.sv @@
`default_nettype none

// Temporal frame accumulator. Pixels stream in raster order on the s_ side;
// the block keeps its own column, row and frame count and returns one result
// per pixel on the m_ side with its position and an end-of-frame tlast. With
// accumulation off a pixel passes through; with it on, the first frame after
// a restart is copied into a per-pixel store, later frames either add into it
// (output = sum / frame count) or blend into it as a single-pole low-pass.
// Writing width or height, or switching accumulation on, restarts the frame.
// A front stage takes one pixel per clock, while the queue has room, into a
// 4-entry queue; the back end works on one pixel at a time around a store
// with a registered read: a passed pixel goes idle to finish, a copy via calc,
// a blend via calc and blend, a sum via calc and the 32-step bit-serial divider.
module frame_accumulator #(
    parameter int MAX_PIXELS  = 1048576,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // pixel_sample
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // pixel_value, pixel_column, pixel_row
    output logic [((SAMPLE_BITS+2*fa_pkg::POS_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                       m_tlast,   // frame_last
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [4:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    import fa_pkg::*;

    localparam int M_TDATA_BITS = ((SAMPLE_BITS + 2*POS_BITS + 7) / 8) * 8;
    localparam int CTL_BITS     = $bits(fa_ctl_t);
    localparam int ENTRY_BITS   = CTL_BITS + SAMPLE_BITS + COUNT_BITS + ALPHA_BITS;

    fa_cfg_t    cfg_reg;
    logic       restart;
    logic       cfg_write;
    logic [2:0] reg_index;

    fa_ctl_t                 f_ctl;
    logic [SAMPLE_BITS-1:0]  f_sample;
    logic [COUNT_BITS-1:0]   f_count;
    logic [ALPHA_BITS-1:0]   f_alpha;
    logic                    f_push;
    logic                    q_push_ready;
    logic [ENTRY_BITS-1:0]   q_in;
    logic [ENTRY_BITS-1:0]   q_out;
    logic                    q_valid;
    logic                    q_pop;

    fa_ctl_t                 b_ctl;
    logic [SAMPLE_BITS-1:0]  b_sample;
    logic [COUNT_BITS-1:0]   b_count;
    logic [ALPHA_BITS-1:0]   b_alpha;

    logic [SAMPLE_BITS-1:0]  out_value;
    logic [POS_BITS-1:0]     out_col;
    logic [POS_BITS-1:0]     out_row;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    always_comb begin
        restart = 1'b0;
        if (cfg_write) begin
            unique case (reg_index)
                REG_WIDTH, REG_HEIGHT: restart = 1'b1;
                REG_ENABLE:            restart = pwdata[0] && !cfg_reg.accumulate_enable;
                default:               restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width       <= RESET_WIDTH;
            cfg_reg.frame_height      <= RESET_HEIGHT;
            cfg_reg.accumulate_enable <= 1'b0;
            cfg_reg.lowpass_mode      <= 1'b0;
            cfg_reg.blend_alpha       <= ALPHA_ONE;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_WIDTH:   cfg_reg.frame_width       <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT:  cfg_reg.frame_height      <= pwdata[DIM_BITS-1:0];
                REG_ENABLE:  cfg_reg.accumulate_enable <= pwdata[0];
                REG_LOWPASS: cfg_reg.lowpass_mode      <= pwdata[0];
                REG_ALPHA:   cfg_reg.blend_alpha       <= pwdata[ALPHA_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_WIDTH:   prdata = 32'(cfg_reg.frame_width);
            REG_HEIGHT:  prdata = 32'(cfg_reg.frame_height);
            REG_ENABLE:  prdata = 32'(cfg_reg.accumulate_enable);
            REG_LOWPASS: prdata = 32'(cfg_reg.lowpass_mode);
            REG_ALPHA:   prdata = 32'(cfg_reg.blend_alpha);
            default:     prdata = '0;
        endcase
    end

    fa_front #(
        .MAX_PIXELS  (MAX_PIXELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .restart  (restart),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_sample (s_tdata[SAMPLE_BITS-1:0]),
        .q_ready  (q_push_ready),
        .q_push   (f_push),
        .q_ctl    (f_ctl),
        .q_sample (f_sample),
        .q_count  (f_count),
        .q_alpha  (f_alpha)
    );

    assign q_in = {f_ctl, f_sample, f_count, f_alpha};

    fa_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_push),
        .push_ready (q_push_ready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_out)
    );

    assign b_alpha  = q_out[ALPHA_BITS-1:0];
    assign b_count  = q_out[ALPHA_BITS +: COUNT_BITS];
    assign b_sample = q_out[ALPHA_BITS+COUNT_BITS +: SAMPLE_BITS];
    assign b_ctl    = fa_ctl_t'(q_out[ENTRY_BITS-1 -: CTL_BITS]);

    fa_back #(
        .MAX_PIXELS  (MAX_PIXELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_pop),
        .q_ctl     (b_ctl),
        .q_sample  (b_sample),
        .q_count   (b_count),
        .q_alpha   (b_alpha),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (out_value),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_last  (m_tlast)
    );

    assign m_tdata = M_TDATA_BITS'({out_row, out_col, out_value});

endmodule

`default_nettype wire

@@ tb/tb_frame_accumulator.sv @@
`default_nettype none

module tb_frame_accumulator;
    import fa_pkg::*;

    localparam int unsigned STORE_PIXELS = 1048576;
    localparam int unsigned FRAME_COUNT_MAX = 65535;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 40;

    // Tracks the block's geometry, frame count and per-pixel store, and keeps
    // the expected result of every accepted pixel in arrival order.
    class frame_scoreboard;
        logic [DIM_BITS-1:0]   width_reg;
        logic [DIM_BITS-1:0]   height_reg;
        logic                  enable_reg;
        logic                  lowpass_reg;
        logic [ALPHA_BITS-1:0] alpha_reg;
        bit [31:0]             pixel_store [int unsigned];
        int unsigned           frames_seen;
        int unsigned           col_pos;
        int unsigned           row_pos;
        bit                    adding;
        bit [36:0]             expected_pixels [$];
        int                    errors;

        function new();
            width_reg   = 11'd640;
            height_reg  = 11'd480;
            enable_reg  = 1'b0;
            lowpass_reg = 1'b0;
            alpha_reg   = 17'h10000;
            errors      = 0;
            restart();
        endfunction

        function void restart();
            frames_seen = 0;
            col_pos     = 0;
            row_pos     = 0;
            adding      = 1'b0;
        endfunction

        function int unsigned dim_of(logic [DIM_BITS-1:0] v);
            if (v == 0) begin
                return 1;
            end
            if (v > 1024) begin
                return 1024;
            end
            return 32'(v);
        endfunction

        function int unsigned frame_pixels();
            return dim_of(width_reg) * dim_of(height_reg);
        endfunction

        function void write_reg(logic [2:0] index, logic [31:0] value);
            case (index)
                REG_WIDTH: begin
                    width_reg = value[DIM_BITS-1:0];
                    restart();
                end
                REG_HEIGHT: begin
                    height_reg = value[DIM_BITS-1:0];
                    restart();
                end
                REG_ENABLE: begin
                    if (value[0] && !enable_reg) begin
                        restart();
                    end
                    enable_reg = value[0];
                end
                REG_LOWPASS: lowpass_reg = value[0];
                REG_ALPHA:   alpha_reg = value[ALPHA_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [15:0] sample);
            int unsigned     w;
            int unsigned     h;
            int unsigned     c;
            int unsigned     r;
            int unsigned     pix;
            longint unsigned x;
            longint unsigned s;
            longint unsigned a;
            longint unsigned result;
            bit              last_bit;
            w = dim_of(width_reg);
            h = dim_of(height_reg);
            c = col_pos;
            r = row_pos;
            if (c >= w) c = 0;
            if (r >= h) r = 0;
            pix = r * w + c;
            x = 64'(sample);
            result = x;
            if (enable_reg) begin
                if (c == 0 && r == 0) begin
                    if (frames_seen == 0) begin
                        frames_seen = 1;
                        adding = 1'b1;
                    end else if (frames_seen < FRAME_COUNT_MAX) begin
                        frames_seen++;
                        adding = 1'b1;
                    end else begin
                        adding = 1'b0;
                    end
                end
                if (pix < STORE_PIXELS && frames_seen != 0) begin
                    s = pixel_store.exists(pix) ? 64'(pixel_store[pix]) : 64'd0;
                    if (frames_seen == 1) begin
                        s = x;
                        result = s;
                    end else if (lowpass_reg) begin
                        a = (alpha_reg > 17'h10000) ? 64'd65536 : 64'(alpha_reg);
                        if (x >= s) begin
                            s += (a * (x - s)) >> 16;
                        end else begin
                            s -= (a * (s - x)) >> 16;
                        end
                        result = s;
                    end else begin
                        if (adding) begin
                            s += x;
                            if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
                        end
                        result = s / 64'(frames_seen);
                    end
                    pixel_store[pix] = s[31:0];
                end
            end
            if (result > 65535) result = 65535;
            last_bit = (c == w - 1) && (r == h - 1);
            expected_pixels.push_back({last_bit, r[9:0], c[9:0], result[15:0]});
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c & 32'h3FF;
            row_pos = r & 32'h3FF;
        endfunction

        function void check_result(logic [15:0] value, logic [9:0] col, logic [9:0] row,
                                   logic last);
            bit [36:0] want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: result with no pixel pending: value %0d col %0d row %0d last %0b",
                         $time, value, col, row, last);
                return;
            end
            want = expected_pixels.pop_front();
            if (value !== want[15:0]) begin
                errors++;
                $display("%0t: pixel_value expected %0d, got %0d", $time, want[15:0], value);
            end
            if (col !== want[25:16]) begin
                errors++;
                $display("%0t: pixel_column expected %0d, got %0d", $time, want[25:16], col);
            end
            if (row !== want[35:26]) begin
                errors++;
                $display("%0t: pixel_row expected %0d, got %0d", $time, want[35:26], row);
            end
            if (last !== want[36]) begin
                errors++;
                $display("%0t: frame_last expected %0b, got %0b", $time, want[36], last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // pixel_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // pixel_value, pixel_column, pixel_row
    logic        m_tlast;    // frame_last
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb;
    bit  quiet;
    int  stall_left;
    int  cycles;

    frame_accumulator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 16'h0000;
        end else if (r == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [31:0] pick_alpha();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd65536;
            2: return $urandom_range(65537, 131071);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Result side: random stalls on m_tready, check on every accepted result.
    initial begin
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 20) begin
                    stall_left = gap_length();
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            sb.check_result(m_tdata[15:0], m_tdata[25:16], m_tdata[35:26], m_tlast);
        end
    end

    // Starts and ends just after a falling edge; leaves the bus idle before returning.
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(index, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Leaves s_tvalid high; the caller drops it once the burst is done.
    task automatic send_pixel(input logic [15:0] sample);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 25) ? gap_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge aclk); while (!s_tready);
        sb.take_pixel(sample);
        @(negedge aclk);
    endtask

    task automatic send_random_pixels(input int count);
        repeat (count) send_pixel(pick_sample());
        s_tvalid <= 1'b0;
    endtask

    // Hold until every expected result is back, then let the back end settle.
    task automatic drain();
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int random_items;
        int count;
        sb = new();
        quiet    = 1'b0;
        cycles   = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // pass-through at the reset geometry
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h5A5A);
        s_tvalid <= 1'b0;
        drain();

        // copy frame, then two running-sum frames on a 2x1 image
        write_reg(REG_WIDTH, 32'd2);
        write_reg(REG_HEIGHT, 32'd1);
        write_reg(REG_ENABLE, 32'd1);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h0001);
        s_tvalid <= 1'b0;
        drain();

        // low-pass on a store holding sums: alpha zero leaves them, output saturates
        write_reg(REG_LOWPASS, 32'd1);
        write_reg(REG_ALPHA, 32'd0);
        send_pixel(16'h0001);
        send_pixel(16'h0002);
        s_tvalid <= 1'b0;
        drain();
        write_reg(REG_ALPHA, 32'h1FFFF);
        send_pixel(16'h0007);
        send_pixel(16'h0009);
        s_tvalid <= 1'b0;
        drain();
        write_reg(REG_ALPHA, 32'd32768);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        s_tvalid <= 1'b0;
        drain();

        // disable at a frame boundary, then re-enable mid-frame to restart on a copy frame
        write_reg(REG_ENABLE, 32'd0);
        send_pixel(16'd1234);
        s_tvalid <= 1'b0;
        drain();
        write_reg(REG_ENABLE, 32'd1);
        send_pixel(16'd4321);
        send_pixel(16'd8);
        s_tvalid <= 1'b0;
        drain();

        // zero geometry acts as 1x1
        write_reg(REG_WIDTH, 32'd0);
        write_reg(REG_HEIGHT, 32'd0);
        send_random_pixels(3);
        drain();

        // random phases on small images, accumulation often carried across phases
        random_items = 0;
        while (random_items < 450) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0) begin
                write_reg(REG_WIDTH, $urandom_range(0, 6));
                write_reg(REG_HEIGHT, $urandom_range(0, 5));
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_ENABLE, ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
            end
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_LOWPASS, $urandom_range(0, 1));
            end
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_ALPHA, pick_alpha());
            end
            count = sb.frame_pixels() * $urandom_range(1, 5)
                    + $urandom_range(0, sb.frame_pixels() - 1);
            send_random_pixels(count);
            random_items += count;
            drain();
        end
        quiet = 1'b0;

        if (sb.expected_pixels.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.expected_pixels.size());
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
